// ===== rtl/vlnw_pkg.sv =====
// Shared constants, types and nibble tables for the voltmeter LCD nibble writer.
// No dependencies; every rtl file refers to it by scoped names.
package vlnw_pkg;

  // ADC resolution and derived full-scale code
  localparam int ADC_BITS = 16;
  localparam int SMP_IN_W = 16;
  localparam int REF_W    = 14;
  localparam int PROD_W   = ADC_BITS + REF_W;
  localparam int MV_W     = REF_W;

  localparam logic [SMP_IN_W-1:0] FULL_CODE =
    SMP_IN_W'((32'd1 << ADC_BITS) - 32'd1);
  localparam logic [PROD_W-1:0]   FULL_PROD = PROD_W'(FULL_CODE);
  localparam logic [PROD_W-1:0]   LOW_MASK  = PROD_W'(FULL_CODE);

  localparam logic [REF_W-1:0] REF_RESET = 14'd5000;

  // divide by ten: (v * 52429) >> 19 is exact for v below 43690
  localparam int              DIV10_W  = 16;
  localparam int              DIV10_SH = 19;
  localparam logic [DIV10_W-1:0] DIV10_MUL = 16'd52429;
  localparam int              DMUL_W   = MV_W + DIV10_W;

  // opcodes
  localparam logic OP_INIT   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // nibble sequencer positions
  localparam int              SEQ_W      = 6;
  localparam logic [SEQ_W-1:0] INIT_LAST  = 6'd15;
  localparam logic [SEQ_W-1:0] CLR_HI_POS = 6'd32;
  localparam logic [SEQ_W-1:0] SMP_LAST   = 6'd33;

  localparam logic [7:0] CHAR_ZERO = 8'h30;

  // one classified job handed from front to back
  typedef struct packed {
    logic       op;
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } job_t;

  // one output word
  typedef struct packed {
    logic [3:0] pins;
    logic       rs;
    logic       last;
  } nib_t;

  // LCD 4-bit init instruction sequence
  function automatic logic [3:0] init_nib(input logic [3:0] idx);
    logic [3:0] n;
    unique case (idx)
      4'd0, 4'd1, 4'd2: n = 4'h3;
      4'd3, 4'd4:       n = 4'h2;
      4'd5, 4'd7:       n = 4'h8;
      4'd9, 4'd15:      n = 4'h1;
      4'd11:            n = 4'h4;
      4'd13:            n = 4'hF;
      default:          n = 4'h0;
    endcase
    return n;
  endfunction

  // "Voltage:X.YYYV  " with digits filled in
  function automatic logic [7:0] text_char(input logic [3:0] pos, input job_t j);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h56; // V
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6C; // l
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h61; // a
      4'd5:    c = 8'h67; // g
      4'd6:    c = 8'h65; // e
      4'd7:    c = 8'h3A; // :
      4'd8:    c = CHAR_ZERO | {4'h0, j.d3};
      4'd9:    c = 8'h2E; // .
      4'd10:   c = CHAR_ZERO | {4'h0, j.d2};
      4'd11:   c = CHAR_ZERO | {4'h0, j.d1};
      4'd12:   c = CHAR_ZERO | {4'h0, j.d0};
      4'd13:   c = 8'h56; // V
      default: c = 8'h20; // space
    endcase
    return c;
  endfunction

  // board wiring: bit3->pin1, bit2->pin3, bit1->pin2, bit0->pin0
  function automatic logic [3:0] map_pins(input logic [3:0] n);
    return {n[2], n[1], n[3], n[0]};
  endfunction

endpackage

// ===== rtl/vlnw_front.sv =====
// Front end: accepts words, holds the reference register, scales the sample to
// millivolts and splits it into decimal digits. Uses vlnw_pkg.
module vlnw_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_opcode,
  input  logic [vlnw_pkg::SMP_IN_W-1:0]   in_adc_sample,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vlnw_pkg::REF_W-1:0]      cfg_data,
  output logic                            job_valid,
  input  logic                            job_ready,
  output vlnw_pkg::job_t                  job
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_FOLD = 3'd2;
  localparam logic [2:0] S_DIG  = 3'd3;
  localparam logic [2:0] S_HOLD = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [vlnw_pkg::REF_W-1:0]    ref_r, ref_nxt;
  logic                          op_r, op_nxt;
  logic [vlnw_pkg::ADC_BITS-1:0] smp_r, smp_nxt;
  logic [vlnw_pkg::PROD_W-1:0]   rem_r, rem_nxt;
  logic [vlnw_pkg::MV_W-1:0]     q_r, q_nxt;
  logic [vlnw_pkg::MV_W-1:0]     v_r, v_nxt;
  logic [1:0]                    dig_cnt_r, dig_cnt_nxt;
  logic [3:0]                    dig_r [3];
  logic [3:0]                    dig_nxt [3];

  logic                          accept;
  logic [vlnw_pkg::SMP_IN_W-1:0] smp_sat;
  logic [vlnw_pkg::PROD_W-1:0]   fold_hi;
  logic [vlnw_pkg::PROD_W-1:0]   fold_lo;
  logic [vlnw_pkg::DMUL_W-1:0]   dmul;
  logic [vlnw_pkg::MV_W-1:0]     dq;
  logic [vlnw_pkg::MV_W-1:0]     dq10;
  logic [3:0]                    drem;
  logic [vlnw_pkg::MV_W-1:0]     thou;

  assign in_full   = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;
  assign job_valid = (state_r == S_HOLD);

  // clamp samples above full scale
  assign smp_sat = (in_adc_sample > vlnw_pkg::FULL_CODE) ? vlnw_pkg::FULL_CODE
                                                           : in_adc_sample;

  // fold step for division by 2^B-1: x = hi*2^B + lo = hi*(2^B-1) + (hi+lo)
  assign fold_hi = rem_r >> vlnw_pkg::ADC_BITS;
  assign fold_lo = rem_r & vlnw_pkg::LOW_MASK;

  // one decimal digit per step
  assign dmul = vlnw_pkg::DMUL_W'(v_r) * vlnw_pkg::DMUL_W'(vlnw_pkg::DIV10_MUL);
  assign dq   = vlnw_pkg::MV_W'(dmul >> vlnw_pkg::DIV10_SH);
  assign dq10 = (dq << 3) + (dq << 1);
  assign drem = 4'(v_r - dq10);
  assign thou = (v_r >= vlnw_pkg::MV_W'(10)) ? (v_r - vlnw_pkg::MV_W'(10)) : v_r;

  assign job.op = op_r;
  assign job.d3 = 4'(thou);
  assign job.d2 = dig_r[2];
  assign job.d1 = dig_r[1];
  assign job.d0 = dig_r[0];

  // sequencing
  always_comb begin
    state_nxt   = state_r;
    ref_nxt     = ref_r;
    op_nxt      = op_r;
    smp_nxt     = smp_r;
    rem_nxt     = rem_r;
    q_nxt       = q_r;
    v_nxt       = v_r;
    dig_cnt_nxt = dig_cnt_r;
    dig_nxt     = dig_r;
    if (cfg_valid) begin
      ref_nxt = cfg_data;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_opcode;
          smp_nxt   = vlnw_pkg::ADC_BITS'(smp_sat);
          state_nxt = (in_opcode == vlnw_pkg::OP_SAMPLE) ? S_MUL : S_HOLD;
        end
      end
      S_MUL: begin
        rem_nxt   = vlnw_pkg::PROD_W'(smp_r) * vlnw_pkg::PROD_W'(ref_r);
        q_nxt     = '0;
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        if (fold_hi != '0) begin
          q_nxt   = q_r + vlnw_pkg::MV_W'(fold_hi);
          rem_nxt = fold_hi + fold_lo;
        end else begin
          v_nxt       = q_r + vlnw_pkg::MV_W'(rem_r == vlnw_pkg::FULL_PROD);
          dig_cnt_nxt = 2'd0;
          state_nxt   = S_DIG;
        end
      end
      S_DIG: begin
        dig_nxt[dig_cnt_r] = drem;
        v_nxt              = dq;
        dig_cnt_nxt        = dig_cnt_r + 2'd1;
        if (dig_cnt_r == 2'd2) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (job_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ref_r   <= vlnw_pkg::REF_RESET;
    end else begin
      state_r <= state_nxt;
      ref_r   <= ref_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    smp_r     <= smp_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    v_r       <= v_nxt;
    dig_cnt_r <= dig_cnt_nxt;
    dig_r     <= dig_nxt;
  end

  // an accepted word always blocks the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_full)
    else $error("front accepted a word but stayed open");

  // offered sample digits are decimal
  a_digits_dec: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && (job.op == vlnw_pkg::OP_SAMPLE) |->
      (job.d0 < 4'd10) && (job.d1 < 4'd10) && (job.d2 < 4'd10) && (job.d3 < 4'd10))
    else $error("non-decimal digit handed to back end");

endmodule

// ===== rtl/vlnw_job_fifo.sv =====
// Two-entry queue of classified jobs between the front and back ends.
// Uses vlnw_pkg for job_t.
module vlnw_job_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           push_ready,
  input  vlnw_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output vlnw_pkg::job_t pop_data
);

  vlnw_pkg::job_t mem_r [2];
  logic           wptr_r, rptr_r;
  logic [1:0]     cnt_r;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem_r[rptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_r ^ do_push;
      rptr_r <= rptr_r ^ do_pop;
      cnt_r  <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/vlnw_back.sv =====
// Back end: walks each job's nibble run and queues words for the LCD port.
// Uses vlnw_pkg for job/nibble types and the nibble tables.
module vlnw_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      job_valid,
  output logic                      job_pop,
  input  vlnw_pkg::job_t            job,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [3:0]                out_data_pins,
  output logic                      out_register_select,
  output logic                      out_last_nibble
);

  logic                        active_r;
  logic [vlnw_pkg::SEQ_W-1:0]  idx_r;
  vlnw_pkg::job_t              job_r;
  vlnw_pkg::nib_t              q_r [2];
  logic                        wptr_r, rptr_r;
  logic [1:0]                  cnt_r;

  vlnw_pkg::nib_t              cur;
  logic [3:0]                  nib;
  logic [7:0]                  chr;
  logic                        emit, load, take;

  // nibble for the current position
  always_comb begin
    chr = vlnw_pkg::text_char(idx_r[4:1], job_r);
    nib = 4'h0;
    cur = '0;
    if (job_r.op == vlnw_pkg::OP_INIT) begin
      nib      = vlnw_pkg::init_nib(idx_r[3:0]);
      cur.rs   = 1'b0;
      cur.last = (idx_r == vlnw_pkg::INIT_LAST);
    end else if (idx_r < vlnw_pkg::CLR_HI_POS) begin
      nib      = idx_r[0] ? chr[3:0] : chr[7:4];
      cur.rs   = 1'b1;
      cur.last = 1'b0;
    end else begin
      // clear display instruction
      nib      = (idx_r == vlnw_pkg::SMP_LAST) ? 4'h1 : 4'h0;
      cur.rs   = 1'b0;
      cur.last = (idx_r == vlnw_pkg::SMP_LAST);
    end
    cur.pins = vlnw_pkg::map_pins(nib);
  end

  assign emit    = active_r && (cnt_r != 2'd2);
  assign load    = job_valid && (!active_r || (emit && cur.last));
  assign job_pop = load;
  assign take    = out_pop && !out_empty;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else if (load) begin
      active_r <= 1'b1;
      idx_r    <= '0;
    end else if (emit) begin
      active_r <= !cur.last;
      idx_r    <= idx_r + vlnw_pkg::SEQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job;
    end
  end

  // output queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_r ^ emit;
      rptr_r <= rptr_r ^ take;
      cnt_r  <= cnt_r + 2'(emit) - 2'(take);
    end
  end

  // output queue storage
  always_ff @(posedge clk) begin
    if (emit) begin
      q_r[wptr_r] <= cur;
    end
  end

  assign out_empty           = (cnt_r == 2'd0);
  assign out_data_pins       = q_r[rptr_r].pins;
  assign out_register_select = q_r[rptr_r].rs;
  assign out_last_nibble     = q_r[rptr_r].last;

  // init runs never go past their final nibble
  a_init_len: assert property (@(posedge clk) disable iff (!rst_n)
    !(active_r && (job_r.op == vlnw_pkg::OP_INIT) && (idx_r > vlnw_pkg::INIT_LAST)))
    else $error("init run overran");

  // a run ends only by emitting its last nibble or loading the next job
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && !emit |=> active_r && $stable(idx_r))
    else $error("sequencer moved without emitting");

endmodule

// ===== rtl/voltmeter_lcd_nibble_writer.sv =====
// Top level of the voltmeter LCD nibble writer: front end, job queue, back end.
// Depends on vlnw_pkg, vlnw_front, vlnw_job_fifo and vlnw_back.
//
//  channel | handshake              | words
//  in_     | in_push / in_full      | opcode, adc_sample
//  out_    | out_pop / out_empty    | data_pins, register_select, last_nibble
//  cfg_    | cfg_valid / cfg_ready  | reference_millivolts (cfg_data)
//
// A sample word yields 34 output words, an init word 16, one per cycle from the
// back-end sequencer when it is not stalled; that sequencer sets the sustained
// rate. The front end takes a sample through multiply, one to three fold steps
// of the divide by full scale, three digit steps and hand-off, an init word
// straight to hand-off, hidden behind the back end by the two-entry job queue.
// Reset is synchronous, active low, with no clearing pass. A stalled out_pop
// holds the output queue and backs up into the sequencer, job queue and in_full.
module voltmeter_lcd_nibble_writer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_opcode,
  input  logic [vlnw_pkg::SMP_IN_W-1:0] in_adc_sample,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [3:0]                    out_data_pins,
  output logic                          out_register_select,
  output logic                          out_last_nibble,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vlnw_pkg::REF_W-1:0]    cfg_data
);

  logic           fj_valid, fj_ready;
  vlnw_pkg::job_t fj_data;
  logic           bj_valid, bj_pop;
  vlnw_pkg::job_t bj_data;

  vlnw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_opcode     (in_opcode),
    .in_adc_sample (in_adc_sample),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .job_valid     (fj_valid),
    .job_ready     (fj_ready),
    .job           (fj_data)
  );

  vlnw_job_fifo u_job_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fj_valid),
    .push_ready (fj_ready),
    .push_data  (fj_data),
    .pop_valid  (bj_valid),
    .pop        (bj_pop),
    .pop_data   (bj_data)
  );

  vlnw_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_valid           (bj_valid),
    .job_pop             (bj_pop),
    .job                 (bj_data),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_data_pins       (out_data_pins),
    .out_register_select (out_register_select),
    .out_last_nibble     (out_last_nibble)
  );

endmodule

// ===== tb/voltmeter_lcd_nibble_writer_tb.sv =====
// Self-checking testbench for voltmeter_lcd_nibble_writer: queue-style driver and monitor,
// a built-in predictor of the LCD nibble stream and phased reference-voltage settings.
// Depends on vlnw_pkg and the voltmeter_lcd_nibble_writer RTL.
module voltmeter_lcd_nibble_writer_tb;

  // LCD init instructions, first nibble in the top bits
  localparam logic [63:0]  LCD_INIT_NIBS = 64'h3332_2808_0104_0F01;
  // display line with blank digits, first character in the top byte
  localparam logic [127:0] READOUT_TEXT  = "Voltage:0.000V  ";
  localparam logic [7:0]   ASCII_ZERO    = 8'h30;
  localparam logic [3:0]   LCD_CLEAR_HI  = 4'h0;
  localparam logic [3:0]   LCD_CLEAR_LO  = 4'h1;
  localparam logic [vlnw_pkg::SMP_IN_W-1:0] ADC_FULL =
    vlnw_pkg::SMP_IN_W'((64'd1 << vlnw_pkg::ADC_BITS) - 64'd1);
  localparam logic [vlnw_pkg::REF_W-1:0]    REF_MAX  = '1;
  localparam int SETTLE_CYCLES = 50;
  localparam int HOLD_AT_ITEM  = 30;
  localparam int HOLD_CYCLES   = 600;
  localparam int RAND_PHASES   = 4;
  localparam int PHASE_ITEMS   = 28;

  typedef struct {
    logic                          op;
    logic [vlnw_pkg::SMP_IN_W-1:0] smp;
    bit                            drain_first;
  } sample_req_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_push = 1'b0;
  logic                          in_full;
  logic                          in_opcode = vlnw_pkg::OP_INIT;
  logic [vlnw_pkg::SMP_IN_W-1:0] in_adc_sample = '0;
  logic                          out_empty;
  logic                          out_pop = 1'b0;
  logic [3:0]                    out_data_pins;
  logic                          out_register_select;
  logic                          out_last_nibble;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [vlnw_pkg::REF_W-1:0]    cfg_data = '0;

  sample_req_t                pending[$];
  vlnw_pkg::nib_t             readout_q[$];
  logic [vlnw_pkg::REF_W-1:0] ref_mv = vlnw_pkg::REF_RESET;
  int            words_predicted = 0;
  int            words_checked = 0;
  int            items_accepted = 0;
  int            mismatches = 0;
  int            send_gap = 0;
  int            pop_gap = 0;
  int            sink_hold_cnt = 0;
  bit            hold_done = 1'b0;
  bit            steady = 1'b0;

  voltmeter_lcd_nibble_writer u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_opcode           (in_opcode),
    .in_adc_sample       (in_adc_sample),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_data_pins       (out_data_pins),
    .out_register_select (out_register_select),
    .out_last_nibble     (out_last_nibble),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  always #1 clk = ~clk;

  // board wiring of the LCD data bus
  function automatic logic [3:0] board_pins(input logic [3:0] n);
    logic [3:0] p;
    p[0] = n[0];
    p[1] = n[3];
    p[2] = n[1];
    p[3] = n[2];
    return p;
  endfunction

  function automatic void queue_nibble(input logic [3:0] n, input logic rs, input logic last);
    vlnw_pkg::nib_t w;
    w.pins = board_pins(n);
    w.rs   = rs;
    w.last = last;
    readout_q.push_back(w);
  endfunction

  // expected nibble stream of one word; returns how many nibbles it adds
  function automatic int predict_readout(input logic op,
                                         input logic [vlnw_pkg::SMP_IN_W-1:0] raw);
    logic [vlnw_pkg::SMP_IN_W-1:0] smp;
    logic [63:0]                   mv;
    logic [127:0]                  text;
    int                            i;
    if (op == vlnw_pkg::OP_INIT) begin
      for (i = 0; i < 16; i++)
        queue_nibble(LCD_INIT_NIBS[63-4*i -: 4], 1'b0, i == 15);
      return 16;
    end
    smp = (raw > ADC_FULL) ? ADC_FULL : raw;
    mv = (64'(smp) * 64'(ref_mv)) / 64'(ADC_FULL);
    text = READOUT_TEXT;
    // digits at text positions 12, 11, 10 and 8; thousands wraps past 9
    text[127-8*12 -: 8] = ASCII_ZERO + 8'(mv % 10);
    mv = mv / 10;
    text[127-8*11 -: 8] = ASCII_ZERO + 8'(mv % 10);
    mv = mv / 10;
    text[127-8*10 -: 8] = ASCII_ZERO + 8'(mv % 10);
    mv = mv / 10;
    text[127-8*8 -: 8]  = ASCII_ZERO + 8'(mv % 10);
    for (i = 0; i < 16; i++) begin
      queue_nibble(text[127-8*i -: 4], 1'b1, 1'b0);
      queue_nibble(text[123-8*i -: 4], 1'b1, 1'b0);
    end
    queue_nibble(LCD_CLEAR_HI, 1'b0, 1'b0);
    queue_nibble(LCD_CLEAR_LO, 1'b0, 1'b1);
    return 34;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // samples biased toward the ends of the range
  function automatic logic [vlnw_pkg::SMP_IN_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return vlnw_pkg::SMP_IN_W'($urandom_range(0, 15));
    if (r == 3)
      return vlnw_pkg::SMP_IN_W'(ADC_FULL - vlnw_pkg::SMP_IN_W'($urandom_range(0, 15)));
    return vlnw_pkg::SMP_IN_W'($urandom);
  endfunction

  // input driver
  always @(posedge clk) begin
    sample_req_t req;
    if (!rst_n) begin
      in_push <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_push && !in_full) begin
        words_predicted <= words_predicted + predict_readout(in_opcode, in_adc_sample);
        items_accepted  <= items_accepted + 1;
      end
      if (!in_push || !in_full) begin
        if (send_gap != 0) begin
          send_gap--;
          in_push <= 1'b0;
        end else if (pending.size() != 0 && !(pending[0].drain_first &&
                     (in_push || words_predicted != words_checked))) begin
          req = pending.pop_front();
          in_push       <= 1'b1;
          in_opcode     <= req.op;
          in_adc_sample <= req.smp;
          send_gap = pick_gap();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // one long output hold-off while the sender keeps pushing
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_hold_cnt <= 0;
      hold_done     <= 1'b0;
    end else if (!hold_done && items_accepted == HOLD_AT_ITEM) begin
      sink_hold_cnt <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else if (sink_hold_cnt != 0) begin
      sink_hold_cnt <= sink_hold_cnt - 1;
    end
  end

  // output monitor and checker
  always @(posedge clk) begin
    vlnw_pkg::nib_t exp_w;
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_gap = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (readout_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, got pins=%h rs=%b last=%b", $time,
                   out_data_pins, out_register_select, out_last_nibble);
          mismatches++;
        end else begin
          exp_w = readout_q.pop_front();
          if ({out_data_pins, out_register_select, out_last_nibble} !== exp_w) begin
            $display("%0t: word %0d: expected pins=%h rs=%b last=%b, got pins=%h rs=%b last=%b",
                     $time, words_checked, exp_w.pins, exp_w.rs, exp_w.last,
                     out_data_pins, out_register_select, out_last_nibble);
            mismatches++;
          end
          words_checked <= words_checked + 1;
        end
        pop_gap = pick_gap();
      end
      if (sink_hold_cnt != 0) begin
        out_pop <= 1'b0;
      end else if (pop_gap != 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic queue_req(input logic op, input logic [vlnw_pkg::SMP_IN_W-1:0] smp,
                           input bit drain_first);
    sample_req_t req;
    req.op          = op;
    req.smp         = smp;
    req.drain_first = drain_first;
    pending.push_back(req);
  endtask

  // wait until every word went in and every nibble came out, then let the block settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || in_push || words_predicted != words_checked);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reference(input logic [vlnw_pkg::REF_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    ref_mv = v;
  endtask

  // stimulus sequence
  initial begin
    int ph;
    int n;
    // reset reference: init, range ends, one count, mid scale, alternating bits, full/5, full-1
    queue_req(vlnw_pkg::OP_INIT, '0, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, '0, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, '1, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, 16'd1, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, 16'h8000, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, 16'h5555, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, 16'hAAAA, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, 16'd13107, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, 16'hFFFE, 1'b0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // top of the specified range
    write_reference(14'd9999);
    queue_req(vlnw_pkg::OP_SAMPLE, '1, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, '0, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, 16'd6554, 1'b0);
    queue_req(vlnw_pkg::OP_INIT, '1, 1'b0);
    wait_idle();

    // register above 9999: thousands digit wraps
    write_reference(REF_MAX);
    queue_req(vlnw_pkg::OP_SAMPLE, '1, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, 16'd40000, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, 16'd45000, 1'b0);
    wait_idle();

    // register zero reads 0.000
    write_reference('0);
    queue_req(vlnw_pkg::OP_SAMPLE, '1, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, 16'd12345, 1'b0);
    wait_idle();

    // smallest nonzero reference
    write_reference(14'd1);
    queue_req(vlnw_pkg::OP_SAMPLE, '1, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, 16'hFFFE, 1'b0);
    queue_req(vlnw_pkg::OP_SAMPLE, 16'h8000, 1'b0);
    wait_idle();

    // random phases, the last one back at the reset reference
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      write_reference((ph == RAND_PHASES - 1) ? vlnw_pkg::REF_RESET
                                              : vlnw_pkg::REF_W'($urandom_range(1, 9999)));
      steady = (ph == 1);
      for (n = 0; n < PHASE_ITEMS; n++)
        queue_req(($urandom_range(0, 9) == 0) ? vlnw_pkg::OP_INIT : vlnw_pkg::OP_SAMPLE,
                  pick_sample(), ph == 2 && n == 12);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("voltmeter_lcd_nibble_writer regression: pass");
    end else begin
      $display("voltmeter_lcd_nibble_writer regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("voltmeter_lcd_nibble_writer regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vlnw_pkg.sv
rtl/vlnw_front.sv
rtl/vlnw_job_fifo.sv
rtl/vlnw_back.sv
rtl/voltmeter_lcd_nibble_writer.sv
tb/voltmeter_lcd_nibble_writer_tb.sv
